// ===== design/arpi_pkg.sv =====
// Shared types and constants for the ambient-rejecting photodiode integrator.
// No dependencies; imported by every module of the block.
`default_nettype none

package arpi_pkg;

  // Datapath sizing
  localparam int NUM_CHANNELS = 7;
  localparam int SAMPLE_BITS  = 12;
  localparam int SUM_BITS     = 32;
  localparam int WIN_BITS     = 10;
  localparam int PAIR_BITS    = 15;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic [WIN_BITS-1:0]           win_t;
  typedef logic [PAIR_BITS-1:0]          pair_t;

  // Saturation bounds of a channel sum
  localparam sum_t SUM_MAX = sum_t'({1'b0, {(SUM_BITS-1){1'b1}}});
  localparam sum_t SUM_MIN = sum_t'({1'b1, {(SUM_BITS-1){1'b0}}});

  localparam pair_t PAIR_MAX     = '1;
  localparam win_t  PERIOD_RESET = win_t'(64);

  // Per-item lane control from the sequencer
  typedef struct packed {
    logic en;    // item accepted this cycle
    logic add;   // LED-on phase: add, else subtract
    logic snap;  // snapshot taken: emit and clear
  } lane_ctl_t;

  // One result item
  typedef struct packed {
    logic                         led_on;
    logic                         snap_valid;
    logic [NUM_CHANNELS-1:0][SUM_BITS-1:0] sums;
    pair_t                        pairs;
  } result_t;

endpackage

`default_nettype wire

// ===== design/arpi_lane.sv =====
// One channel lane: saturating on-minus-off accumulator with snapshot clear.
// Depends on arpi_pkg.
`default_nettype none

module arpi_lane
  import arpi_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  lane_ctl_t ctl_i,
  input  sample_t   sample_i,
  output sum_t      snap_o
);

  sum_t                   sum_q, sum_d;
  logic signed [SUM_BITS:0] wide_sum;
  logic signed [SUM_BITS:0] ext_sample;
  logic signed [SUM_BITS:0] ext_sum;
  sum_t                   acc;

  // Add or subtract one sample with a guard bit, then clamp
  always_comb begin
    ext_sample = (SUM_BITS+1)'(sample_i);
    ext_sum    = (SUM_BITS+1)'(sum_q);
    wide_sum   = ctl_i.add ? (ext_sum + ext_sample) : (ext_sum - ext_sample);
    if (wide_sum[SUM_BITS] != wide_sum[SUM_BITS-1]) begin
      acc = wide_sum[SUM_BITS] ? SUM_MIN : SUM_MAX;
    end else begin
      acc = sum_t'(wide_sum[SUM_BITS-1:0]);
    end
    sum_d  = ctl_i.snap ? '0 : acc;
    snap_o = ctl_i.snap ? acc : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctl_i.en) begin
      sum_q <= sum_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/arpi_ctrl.sv =====
// Phase, pair and window sequencer plus the period register.
// Depends on arpi_pkg; drives the lane control of all channels.
`default_nettype none

module arpi_ctrl
  import arpi_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       cfg_we_i,
  input  win_t      cfg_wdata_i,
  input  wire       accept_i,
  input  wire       request_i,
  output lane_ctl_t ctl_o,
  output logic      led_on_o,
  output pair_t     pairs_o
);

  logic  phase_q, phase_d;
  pair_t pairs_q, pairs_d, pairs_inc;
  win_t  win_q, win_d, win_inc;
  win_t  period_q;
  logic  wrap;
  logic  snap;

  // Next state per accepted item
  always_comb begin
    pairs_inc = (pairs_q == PAIR_MAX) ? pairs_q : pairs_q + pair_t'(1);
    win_inc   = win_q + win_t'(1);
    wrap      = !phase_q && (win_inc >= period_q);
    snap      = wrap && request_i;
    phase_d   = !phase_q;
    pairs_d   = pairs_q;
    win_d     = win_q;
    if (!phase_q) begin
      pairs_d = snap ? '0 : pairs_inc;
      win_d   = wrap ? '0 : win_inc;
    end
  end

  assign ctl_o.en   = accept_i;
  assign ctl_o.add  = phase_q;
  assign ctl_o.snap = accept_i && snap;
  assign led_on_o   = phase_d;
  assign pairs_o    = snap ? pairs_inc : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b1;
      pairs_q <= '0;
      win_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pairs_q <= pairs_d;
      win_q   <= win_d;
    end
  end

  // Period register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  // Every accepted item flips the LED phase
  a_phase_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> (phase_q != $past(phase_q)))
    else $error("phase did not toggle");

  // A snapshot restarts the window and the pair count
  a_snap_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.snap |=> (win_q == '0 && pairs_q == '0))
    else $error("snapshot did not clear counters");

  // Snapshots only close an off phase
  a_snap_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.snap |-> !phase_q)
    else $error("snapshot in on phase");

endmodule

`default_nettype wire

// ===== design/arpi_outbuf.sv =====
// Output register with a one-entry skid stage for result items.
// Depends on arpi_pkg.
`default_nettype none

module arpi_outbuf
  import arpi_pkg::*;
(
  input  wire     clk_i,
  input  wire     rst_ni,
  input  wire     in_valid_i,
  output logic    in_stall_o,
  input  result_t in_data_i,
  output logic    out_valid_o,
  input  wire     out_stall_i,
  output result_t out_data_o
);

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    accept, take;

  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !skid_valid_q;
  assign take        = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      if (out_valid_q && !take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (out_valid_q && !take) begin
        skid_q <= in_data_i;
      end else begin
        out_q <= in_data_i;
      end
    end else if (take && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  // Skid never holds an item ahead of an empty output register
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid full with output empty");

  // Skid fills only when the output was held
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid filled without a stall");

  // A skid item moves up when the output is taken
  a_skid_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && take) |=> (out_valid_q && !skid_valid_q && out_q == $past(skid_q)))
    else $error("skid item lost");

endmodule

`default_nettype wire

// ===== design/ambient_rejecting_photodiode_integrator_top.sv =====
// Top level of the ambient-rejecting photodiode integrator.
// Depends on arpi_pkg, arpi_lane, arpi_ctrl and arpi_outbuf.
//
// One item (a sweep of seven samples plus a request flag) is accepted per clock
// cycle while in_stall_o is low; the seven channel lanes update their saturating
// accumulators in parallel in that cycle. Each result item is registered in the
// output register or the skid stage, and every item yields exactly one result
// item. A one-entry skid stage sits behind the output register, so an item is
// still taken while a result waits; in_stall_o rises only when both are full.
// oversample_pairs is written through cfg_we_i and cfg_wdata_i; the user must do
// so only while the block is idle (not enforced by the block); reset value 64.
`default_nettype none

module ambient_rejecting_photodiode_integrator_top
  import arpi_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [9:0]  cfg_wdata_i,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  signed [11:0] sample_0_i,
  input  wire  signed [11:0] sample_1_i,
  input  wire  signed [11:0] sample_2_i,
  input  wire  signed [11:0] sample_3_i,
  input  wire  signed [11:0] sample_4_i,
  input  wire  signed [11:0] sample_5_i,
  input  wire  signed [11:0] sample_6_i,
  input  wire         request_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic        led_on_o,
  output logic        snapshot_valid_o,
  output logic signed [31:0] sum_0_o,
  output logic signed [31:0] sum_1_o,
  output logic signed [31:0] sum_2_o,
  output logic signed [31:0] sum_3_o,
  output logic signed [31:0] sum_4_o,
  output logic signed [31:0] sum_5_o,
  output logic signed [31:0] sum_6_o,
  output logic [14:0] pair_count_o
);

  sample_t   samples [NUM_CHANNELS];
  sum_t      snaps   [NUM_CHANNELS];
  lane_ctl_t ctl;
  logic      accept;
  logic      led_on;
  pair_t     pairs;
  result_t   res_in, res_out;

  assign samples[0] = sample_0_i;
  assign samples[1] = sample_1_i;
  assign samples[2] = sample_2_i;
  assign samples[3] = sample_3_i;
  assign samples[4] = sample_4_i;
  assign samples[5] = sample_5_i;
  assign samples[6] = sample_6_i;

  assign accept = in_valid_i && !in_stall_o;

  // Sequencer
  arpi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(win_t'(cfg_wdata_i)),
    .accept_i   (accept),
    .request_i  (request_i),
    .ctl_o      (ctl),
    .led_on_o   (led_on),
    .pairs_o    (pairs)
  );

  // Channel lanes
  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane
    arpi_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .sample_i(samples[g]),
      .snap_o  (snaps[g])
    );
    assign res_in.sums[g] = snaps[g];
  end

  // Merge lane snapshots with the sequencer outputs
  assign res_in.led_on     = led_on;
  assign res_in.snap_valid = ctl.snap;
  assign res_in.pairs      = pairs;

  arpi_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (res_in),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (res_out)
  );

  assign led_on_o         = res_out.led_on;
  assign snapshot_valid_o = res_out.snap_valid;
  assign sum_0_o          = $signed(res_out.sums[0]);
  assign sum_1_o          = $signed(res_out.sums[1]);
  assign sum_2_o          = $signed(res_out.sums[2]);
  assign sum_3_o          = $signed(res_out.sums[3]);
  assign sum_4_o          = $signed(res_out.sums[4]);
  assign sum_5_o          = $signed(res_out.sums[5]);
  assign sum_6_o          = $signed(res_out.sums[6]);
  assign pair_count_o     = res_out.pairs;

endmodule

`default_nettype wire
